@@ sv/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared definitions of the LFU cache table
// Field widths, register map, operation codes and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_BITS       = 32;
  localparam int VALUE_BITS     = 32;
  localparam int CAP_BITS       = 5;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // APB register map: one 32-bit register per word.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-3:0] REG_CAPACITY = 1'b0;

  // What the commit cycle does to the entry table.
  typedef logic [1:0] lfu_op_t;
  localparam lfu_op_t OP_NONE  = 2'd0;
  localparam lfu_op_t OP_HIT   = 2'd1;
  localparam lfu_op_t OP_FILL  = 2'd2;
  localparam lfu_op_t OP_EVICT = 2'd3;

  typedef struct packed {
    logic    load_req;
    logic    pick_slot;
    logic    pick_victim;
    logic    commit;
    lfu_op_t op;
  } lfu_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic cap_zero;
    logic put;
  } lfu_stat_t;

  // Index width for n entries, at least one bit.
  function automatic int idx_bits(input int n);
    int w;
    w = (n <= 2) ? 1 : $clog2(n);
    return w;
  endfunction

endpackage

@@ sv/lfu_req_if.sv @@
// ----------------------------------------------------------------------------
// lfu_req_if: request channel of the LFU cache table
// Valid/ready channel that carries one get or put request per word.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, output command, output key, output write_value,
                  input ready);
  modport sink   (input valid, input command, input key, input write_value,
                  output ready);

endinterface

@@ sv/lfu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lfu_rsp_if: result channel of the LFU cache table
// Valid/ready channel that carries one result word per request.
// ----------------------------------------------------------------------------
interface lfu_rsp_if import lfu_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);

endinterface

@@ sv/lfu_victim_tree.sv @@
// ----------------------------------------------------------------------------
// lfu_victim_tree: registered minimum tree for the replacement choice
// Finds the valid entry with the lowest use count, the least recent among
// equal counts. One tree level per cycle; every level of the tree is registered.
// ----------------------------------------------------------------------------
module lfu_victim_tree import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic [ENTRIES-1:0]            entry_valid,
  input  logic [COUNT_BITS-1:0]         use_count [ENTRIES],
  input  logic [idx_bits(ENTRIES)-1:0]  entry_rank [ENTRIES],
  output logic [idx_bits(ENTRIES)-1:0]  victim_idx
);

  localparam int IDX_BITS = idx_bits(ENTRIES);
  localparam int LEAVES   = 1 << IDX_BITS;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_BITS-1:0]   rank;
    logic [IDX_BITS-1:0]   idx;
  } node_t;

  node_t node_leaf [LEAVES];
  node_t node_q    [1:LEAVES-1];

  // Prefer b only if it is valid and strictly better than a.
  function automatic node_t pick(input node_t a, input node_t b);
    logic take_b;
    take_b = b.valid && (!a.valid || (b.count < a.count) ||
                         ((b.count == a.count) && (b.rank > a.rank)));
    return take_b ? b : a;
  endfunction

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < ENTRIES) begin : g_real
      assign node_leaf[j] = '{entry_valid[j], use_count[j], entry_rank[j], IDX_BITS'(j)};
    end else begin : g_pad
      assign node_leaf[j] = '0;
    end
  end

  // Heap layout: node k has children 2k and 2k+1; indexes at or above
  // LEAVES refer to the leaves.
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    if (2 * k >= LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node_q[k] <= pick(node_leaf[2*k-LEAVES], node_leaf[2*k+1-LEAVES]);
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_q[k] <= pick(node_q[2*k], node_q[2*k+1]);
      end
    end
  end

  assign victim_idx = node_q[1].idx;

endmodule

@@ sv/lfu_datapath.sv @@
// ----------------------------------------------------------------------------
// lfu_datapath: entry table, key compare and result register
// Holds the entries, compares the request key against all of them, picks
// the slot, applies the commit and loads the result word.
// ----------------------------------------------------------------------------
module lfu_datapath import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CAP_BITS-1:0]   capacity,
  input  lfu_cmd_t              cmd,
  output lfu_stat_t             stat,
  input  logic                  in_command,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_write_value,
  output logic                  out_hit,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic                  out_evicted,
  output logic [KEY_BITS-1:0]   out_evicted_key
);

  localparam int IDX_BITS  = idx_bits(ENTRIES);
  localparam int USED_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (USED_BITS > CAP_BITS) ? USED_BITS : CAP_BITS;

  logic                  req_cmd;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic [ENTRIES-1:0]    entry_valid;
  logic [KEY_BITS-1:0]   entry_key   [ENTRIES];
  logic [VALUE_BITS-1:0] entry_value [ENTRIES];
  logic [COUNT_BITS-1:0] use_count   [ENTRIES];
  logic [IDX_BITS-1:0]   entry_rank  [ENTRIES];
  logic [USED_BITS-1:0]  entries_used;

  logic [ENTRIES-1:0]    match_vec;
  logic [IDX_BITS-1:0]   slot;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [IDX_BITS-1:0]   free_idx;
  logic [IDX_BITS-1:0]   victim_idx;
  logic [USED_BITS-1:0]  old_rank;
  logic                  hit_any;

  lfu_victim_tree #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_tree (
    .clk         (clk),
    .entry_valid (entry_valid),
    .use_count   (use_count),
    .entry_rank  (entry_rank),
    .victim_idx  (victim_idx)
  );

  // Lowest matching index and lowest free index.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IDX_BITS'(i);
      if (!entry_valid[i]) free_idx = IDX_BITS'(i);
    end
  end

  assign hit_any = |match_vec;

  // A fill takes the next rank below all held entries.
  assign old_rank = (cmd.op == OP_FILL) ? entries_used : USED_BITS'(entry_rank[slot]);

  always_comb begin
    stat.hit      = hit_any;
    stat.put      = req_cmd;
    stat.cap_zero = (capacity == '0);
    stat.full     = (CMP_BITS'(entries_used) >= CMP_BITS'(capacity)) ||
                    (entries_used == USED_BITS'(ENTRIES));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] <= entry_valid[i] && (entry_key[i] == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      entries_used <= '0;
    end else if (cmd.commit && (cmd.op != OP_NONE)) begin
      entry_valid[slot] <= 1'b1;
      if (cmd.op == OP_FILL) entries_used <= entries_used + USED_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd   <= in_command;
      req_key   <= in_key;
      req_value <= in_write_value;
    end
    if (cmd.pick_slot) begin
      slot <= hit_any ? hit_idx : free_idx;
    end else if (cmd.pick_victim) begin
      slot <= victim_idx;
    end
    if (cmd.commit) begin
      out_hit         <= (cmd.op == OP_HIT);
      out_read_value  <= ((cmd.op == OP_HIT) && !req_cmd) ? entry_value[slot] : '0;
      out_evicted     <= (cmd.op == OP_EVICT);
      out_evicted_key <= (cmd.op == OP_EVICT) ? entry_key[slot] : '0;
      if (cmd.op != OP_NONE) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_BITS'(i) == slot) begin
            entry_rank[i] <= '0;
            if (cmd.op == OP_HIT) begin
              if (req_cmd) entry_value[i] <= req_value;
              if (!(&use_count[i])) use_count[i] <= use_count[i] + COUNT_BITS'(1);
            end else begin
              entry_key[i]   <= req_key;
              entry_value[i] <= req_value;
              use_count[i]   <= COUNT_BITS'(1);
            end
          end else if (entry_valid[i] && (USED_BITS'(entry_rank[i]) < old_rank)) begin
            entry_rank[i] <= entry_rank[i] + IDX_BITS'(1);
          end
        end
      end
    end
  end

endmodule

@@ sv/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl: request sequencer of the LFU cache table
// Steps one request through compare, decision, victim search and commit,
// and owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  lfu_stat_t stat,
  output lfu_cmd_t  cmd
);

  localparam int LEVELS    = idx_bits(ENTRIES);
  localparam int WAIT_BITS = $clog2(LEVELS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  lfu_op_t              op;
  lfu_op_t              op_next;
  logic [WAIT_BITS-1:0] wait_cnt;
  logic [WAIT_BITS-1:0] wait_cnt_next;
  logic                 out_valid;
  logic                 out_free;

  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next    = state;
    op_next       = op;
    wait_cnt_next = wait_cnt;
    cmd           = '0;
    cmd.op        = op;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.pick_slot = 1'b1;
        if (stat.hit) begin
          op_next    = OP_HIT;
          state_next = S_COMMIT;
        end else if (!stat.put || stat.cap_zero) begin
          op_next    = OP_NONE;
          state_next = S_COMMIT;
        end else if (!stat.full) begin
          op_next    = OP_FILL;
          state_next = S_COMMIT;
        end else begin
          op_next       = OP_EVICT;
          wait_cnt_next = '0;
          state_next    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (wait_cnt == WAIT_BITS'(LEVELS - 1)) begin
          cmd.pick_victim = 1'b1;
          state_next      = S_COMMIT;
        end else begin
          wait_cnt_next = wait_cnt + WAIT_BITS'(1);
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_NONE;
      wait_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      wait_cnt <= wait_cnt_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/lfu_cache_table_top.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table_top: key-value cache with LFU replacement, LRU tie break
// Each request word is a get or a put and gives exactly one result word
// (hit flag, value read, eviction flag and evicted key). Requests are
// handled one at a time: a get, a put that hits, or a put that fills a free
// slot goes from acceptance to the result register through accept, key
// compare against all entries, decision and commit. A put that misses while
// the table is full (at least capacity_in_use entries or all ENTRIES held)
// and capacity_in_use is not zero also waits for the registered minimum tree
// that picks the victim, one level per cycle. The result register
// separates the two channels, so the next request word is accepted while
// the previous result word still waits to be taken; a commit waits only if
// that register is still full. The entry table sits in flip-flops, valid
// bits are cleared by reset and no clearing pass is needed.
// capacity_in_use lives at byte address 0 and must only be written while
// no request is in flight.
// ----------------------------------------------------------------------------
module lfu_cache_table_top import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  lfu_req_if.sink                  req,
  lfu_rsp_if.source                rsp,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [CAP_BITS-1:0]   capacity;
  logic                  reg_sel;
  lfu_cmd_t              cmd;
  lfu_stat_t             stat;
  logic                  req_ready;
  logic                  rsp_valid;
  logic                  dp_hit;
  logic [VALUE_BITS-1:0] dp_read_value;
  logic                  dp_evicted;
  logic [KEY_BITS-1:0]   dp_evicted_key;

  // Configuration port. The register is selected by the word address;
  // the byte offset bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY);
  assign prdata  = reg_sel ? APB_DATA_BITS'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  lfu_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfu_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .capacity        (capacity),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (req.command),
    .in_key          (req.key),
    .in_write_value  (req.write_value),
    .out_hit         (dp_hit),
    .out_read_value  (dp_read_value),
    .out_evicted     (dp_evicted),
    .out_evicted_key (dp_evicted_key)
  );

  assign req.ready       = req_ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = dp_hit;
  assign rsp.read_value  = dp_read_value;
  assign rsp.evicted     = dp_evicted;
  assign rsp.evicted_key = dp_evicted_key;

  // A commit never overwrites a result word that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp.ready))
    else $error("commit while the result register is occupied");

  // Every commit shows up as a result word in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not produce a result word");

  // An accepted request always passes through the key compare first.
  a_no_fast_commit: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req_ready) |=> !cmd.commit)
    else $error("commit in the cycle after acceptance");

  // Eviction only happens on a miss with the table at capacity.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (cmd.op == OP_EVICT)) |-> (stat.full && !stat.hit && !stat.cap_zero))
    else $error("eviction without a full table");

endmodule

@@ dv/lfu_cache_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table_top_tb: self-checking testbench of the LFU cache table
// Drives get and put words through the request channel, programs the capacity
// over APB and checks every result word against a cycle-free mirror of the
// cache that keeps its own keys, values, use counts and recency ranks.
// ----------------------------------------------------------------------------
module lfu_cache_table_top_tb;
  import lfu_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_PCT     = 13;
  localparam int TABLE_ENTRIES = DEF_ENTRIES;
  localparam int COUNT_W       = DEF_COUNT_BITS;
  localparam int RANK_W        = $clog2(TABLE_ENTRIES);
  localparam int NO_SLOT       = -1;
  localparam int POOL_MAX      = 32;
  // Touches per entry in the use-count ordering phase.
  localparam int ORDER_TOUCHES = 20;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // The spare index lies just past the only register; writes to it must vanish.
  localparam logic [APB_ADDR_BITS-3:0] REG_SPARE = 1'b1;
  localparam logic [APB_ADDR_BITS-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  localparam bit [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } reply_t;

  // Mirror of the cache table. note_request applies an accepted request word
  // to the mirror and queues the reply it must produce; check_reply compares
  // each reply word taken from the block with the oldest queued one.
  class cache_mirror;
    bit                    slot_valid [TABLE_ENTRIES];
    bit [KEY_BITS-1:0]     slot_key   [TABLE_ENTRIES];
    bit [VALUE_BITS-1:0]   slot_value [TABLE_ENTRIES];
    bit [COUNT_W-1:0]      slot_uses  [TABLE_ENTRIES];
    bit [RANK_W-1:0]       slot_rank  [TABLE_ENTRIES];
    int unsigned           slots_filled;
    bit [CAP_BITS-1:0]     capacity;
    reply_t                replies_due [$];
    int unsigned           failures;
    int unsigned           requests_seen;
    int unsigned           replies_checked;
    int unsigned           hits_seen;
    int unsigned           evictions_seen;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      slots_filled = 0;
      capacity     = CAP_RESET;
    endfunction

    // Slot s becomes the most recent; valid slots newer than old_rank age by one.
    function void promote(int s, int old_rank);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (i != s && slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
      end
      slot_rank[s] = '0;
    endfunction

    function int find_slot(bit [KEY_BITS-1:0] k);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_valid[i] && slot_key[i] == k) return i;
      end
      return NO_SLOT;
    endfunction

    // Lowest use count wins; among equal counts the least recent one.
    function int pick_victim();
      int best;
      best = NO_SLOT;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_valid[i] && (best == NO_SLOT || slot_uses[i] < slot_uses[best] ||
            (slot_uses[i] == slot_uses[best] && slot_rank[i] > slot_rank[best])))
          best = i;
      end
      return best;
    endfunction

    function int first_free();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_valid[i]) return i;
      end
      return NO_SLOT;
    endfunction

    function reply_t serve_request(logic cmd, bit [KEY_BITS-1:0] k,
                                   bit [VALUE_BITS-1:0] v);
      reply_t r;
      int     s;
      int     old_rank;
      int     limit;
      r     = '0;
      limit = (capacity > TABLE_ENTRIES) ? TABLE_ENTRIES : capacity;
      s     = find_slot(k);
      if (s != NO_SLOT) begin
        r.hit = 1'b1;
        if (cmd == CMD_GET) r.read_value = slot_value[s];
        else slot_value[s] = v;
        if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
        promote(s, slot_rank[s]);
      end else if (cmd == CMD_PUT && limit > 0) begin
        if (slots_filled >= limit) begin
          s        = pick_victim();
          old_rank = 0;
          if (s != NO_SLOT) begin
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[s];
            old_rank      = slot_rank[s];
          end
        end else begin
          s        = first_free();
          old_rank = slots_filled;
          if (s != NO_SLOT) slots_filled++;
        end
        if (s != NO_SLOT) begin
          slot_valid[s] = 1'b1;
          slot_key[s]   = k;
          slot_value[s] = v;
          slot_uses[s]  = 1;
          promote(s, old_rank);
        end
      end
      return r;
    endfunction

    function void note_request(logic cmd, bit [KEY_BITS-1:0] k, bit [VALUE_BITS-1:0] v);
      reply_t r;
      r = serve_request(cmd, k, v);
      requests_seen++;
      if (r.hit) hits_seen++;
      if (r.evicted) evictions_seen++;
      replies_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        failures++;
        $display("%0t: reply word with no request pending: %h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      compare_field("hit", want.hit, got.hit);
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  cache_mirror board;
  int unsigned stall_pct;
  int unsigned cycle_count = 0;

  lfu_cache_table_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog. The slowest legal run stays far below this limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. Every word taken from the block goes to the mirror for a
  // check. Ready then stalls at random at the same rate as the request side,
  // so that back-pressure holds the commit until the result register is free.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_reply({rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key});
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one request word, possibly after a random gap, and returns at the
  // clock edge at which the block takes it. Valid stays high on return so
  // that back-to-back words need no bubble.
  task automatic send_request(input logic cmd, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < stall_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.key         <= k;
    req_ch.write_value <= v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    board.note_request(cmd, k, v);
  endtask

  // Lowers valid in the step of the last acceptance and waits until every
  // reply has come back, which leaves the block idle. The register must only
  // change while nothing is in flight.
  task automatic finish_batch();
    req_ch.valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
  endtask

  // Both APB tasks start on a fresh edge so that psel is never assigned twice
  // in one step when a read follows a write.
  task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_BITS-1:0] addr,
                          output logic [APB_DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [APB_DATA_BITS-1:0] got;
    apb_read(CAP_ADDR, got);
    if (got[CAP_BITS-1:0] !== board.capacity) begin
      board.failures++;
      $display("%0t: capacity readback mismatch: expected %h, got %h",
               $time, board.capacity, got[CAP_BITS-1:0]);
    end
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] value);
    finish_batch();
    apb_write(CAP_ADDR, {{(APB_DATA_BITS - CAP_BITS){1'b0}}, value});
    board.capacity = value;
    check_capacity_readback();
  endtask

  // Random traffic over a small key pool, so that hits, refills and evictions
  // all come often. The pool always holds the all-zero and all-one keys; about
  // one word in seven uses a fresh random key instead, which nearly always
  // misses.
  task automatic run_random_batch(input int unsigned count, input int unsigned pool_size);
    logic [KEY_BITS-1:0] pool [POOL_MAX];
    logic [KEY_BITS-1:0] k;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) pool[i] = $urandom;
    repeat (count) begin
      if ($urandom_range(99) < 85) k = pool[$urandom_range(pool_size - 1)];
      else k = $urandom;
      send_request(1'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] key_b;

    board = new();
    stall_pct = STALL_PCT;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_GET;
    req_ch.key         <= '0;
    req_ch.write_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The register must come out of reset at its documented value.
    check_capacity_readback();

    // Use-count ordering. This has to run first, since entries are never
    // freed once held: with two slots, the first entry is touched one time
    // more than the second, and the second is touched last. A put miss must
    // then remove the second one, the more recent entry with the lower
    // count. This is also the long stretch with no stalls on either side.
    stall_pct = 0;
    key_a = $urandom;
    key_b = key_a ^ 32'h0000_0001;
    set_capacity(2);
    send_request(CMD_PUT, key_a, $urandom);
    send_request(CMD_PUT, key_b, $urandom);
    repeat (ORDER_TOUCHES) send_request(1'($urandom_range(1)), key_a, $urandom);
    send_request(CMD_GET, key_a, $urandom);
    repeat (ORDER_TOUCHES) send_request(1'($urandom_range(1)), key_b, $urandom);
    send_request(CMD_PUT, key_a ^ 32'h0000_0002, $urandom);
    send_request(CMD_GET, key_b, $urandom);
    send_request(CMD_GET, key_a, $urandom);
    stall_pct = STALL_PCT;

    // Extreme keys and values with both commands: a get miss, fills, get
    // hits, and a put hit that overwrites the value.
    set_capacity(16);
    send_request(CMD_GET, '0, '1);
    send_request(CMD_PUT, '0, '1);
    send_request(CMD_PUT, '1, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_GET, '1, '1);
    send_request(CMD_PUT, '0, '0);
    send_request(CMD_GET, '0, '1);
    send_request(CMD_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(CMD_GET, 32'hAAAA_AAAA, 32'h5555_5555);

    // Capacity lowered below the number of entries held: nothing goes at
    // once, but every put miss now evicts.
    set_capacity(2);
    send_request(CMD_PUT, 32'h8000_0001, 32'h1234_5678);
    send_request(CMD_GET, '1, '0);

    // A write to the index past the register list must change nothing. Zero
    // is written there, so a wrong decode would also stop the next put.
    finish_batch();
    apb_write(SPARE_ADDR, '0);
    check_capacity_readback();
    send_request(CMD_PUT, 32'h7FFF_FFFE, 32'h8765_4321);

    // With zero capacity a put miss stores nothing, while gets and put hits
    // keep working on the entries already held.
    set_capacity(0);
    send_request(CMD_PUT, 32'h0000_0012, 32'hDEAD_BEEF);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_PUT, 32'h7FFF_FFFE, 32'h0F0F_0F0F);
    send_request(CMD_GET, 32'h0000_0012, '0);

    // The largest code the register holds acts as a full table.
    set_capacity(31);
    for (int i = 0; i < 3; i++) send_request(CMD_PUT, 32'h0000_0013 + i, $urandom);
    set_capacity(1);
    send_request(CMD_PUT, 32'h0000_0020, 32'hCAFE_F00D);
    send_request(CMD_GET, 32'h0000_0020, '0);

    // Random phases at several capacities. The pool size tracks the capacity
    // so that hits and evictions stay balanced; the third phase runs without
    // stalls.
    set_capacity(16);
    run_random_batch(300, 22);
    set_capacity(5);
    run_random_batch(200, 8);
    set_capacity(31);
    stall_pct = 0;
    run_random_batch(200, 20);
    stall_pct = STALL_PCT;
    set_capacity(1);
    run_random_batch(150, 3);
    set_capacity(0);
    run_random_batch(100, 20);
    set_capacity(9);
    run_random_batch(300, 24);

    finish_batch();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d replies to %0d requests: %0d hits and %0d evictions.",
             board.replies_checked, board.requests_seen, board.hits_seen,
             board.evictions_seen);
    $display("Capacities 0, 1, 2, 5, 9, 16 and 31 were used; one phase checked that the count "
             , "outranks recency.");
    if (board.failures == 0 && board.replies_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_victim_tree.sv
sv/lfu_datapath.sv
sv/lfu_ctrl.sv
sv/lfu_cache_table_top.sv
dv/lfu_cache_table_top_tb.sv
